[rtl/oad_pkg.sv]
// ----------------------------------------------------------------------------
// oad_pkg: shared types and constants of the obstacle avoidance drive block
// Sensor weight tables, wall flag map, stage payload and mode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package oad_pkg;

  // field widths
  localparam int IDX_W    = 4;
  localparam int RD_W     = 10;
  localparam int CFG_W    = 16;
  localparam int CFG_IX_W = 2;
  localparam int WT_W     = 10;
  localparam int MOD_W    = 10;
  localparam int PROD_W   = WT_W + MOD_W;
  localparam int TOT_W    = 22;
  localparam int SPD_W    = 17;
  localparam int DM_W     = 2;
  localparam int WALL_W   = 4;
  localparam int IN_TD_W  = 16;
  localparam int OUT_TD_W = 40;

  localparam int NUM_SENSORS_DEF = 16;

  // near level and the offset of 10*v
  localparam logic [RD_W-1:0] NEAR_LEVEL = 10'd922;
  localparam logic [13:0]     MOD_OFFSET = 14'd9216;

  // configuration register indexes
  localparam logic [CFG_IX_W-1:0] REG_WEIGHT_THRESHOLD = 2'd0;
  localparam logic [CFG_IX_W-1:0] REG_FULL_SPEED       = 2'd1;
  localparam logic [CFG_IX_W-1:0] REG_TURN_SPEED       = 2'd2;

  localparam logic [CFG_W-1:0] THRESHOLD_RST  = 16'd100;
  localparam logic [CFG_W-1:0] FULL_SPEED_RST = 16'd5240;
  localparam logic [CFG_W-1:0] TURN_SPEED_RST = 16'd3668;

  // drive mode codes as seen on the result beat
  localparam logic [DM_W-1:0] DRIVE_FORWARD = 2'd0;
  localparam logic [DM_W-1:0] DRIVE_LEFT    = 2'd1;
  localparam logic [DM_W-1:0] DRIVE_RIGHT   = 2'd2;

  // internal mode state
  typedef enum logic [2:0] {
    MODE_FWD   = 3'b001,
    MODE_LEFT  = 3'b010,
    MODE_RIGHT = 3'b100
  } mode_t;

  // decoded sample handed from the input stage to the core
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              near;
    logic              zero;
    logic [WALL_W-1:0] wall_mask;
    logic [PROD_W-1:0] lprod;
    logic [PROD_W-1:0] rprod;
  } stage_t;

  function automatic logic [WT_W-1:0] left_weight(input logic [IDX_W-1:0] idx);
    case (idx)
      4'd0:    left_weight = 10'd150;
      4'd1:    left_weight = 10'd200;
      4'd2:    left_weight = 10'd300;
      4'd3:    left_weight = 10'd600;
      default: left_weight = 10'd0;
    endcase
  endfunction

  function automatic logic [WT_W-1:0] right_weight(input logic [IDX_W-1:0] idx);
    case (idx)
      4'd4:    right_weight = 10'd600;
      4'd5:    right_weight = 10'd300;
      4'd6:    right_weight = 10'd200;
      4'd7:    right_weight = 10'd150;
      default: right_weight = 10'd0;
    endcase
  endfunction

  // front, right, back, left sensors
  function automatic logic [WALL_W-1:0] wall_mask_of(input logic [IDX_W-1:0] idx);
    case (idx)
      4'd4:    wall_mask_of = 4'b0001;
      4'd7:    wall_mask_of = 4'b0010;
      4'd12:   wall_mask_of = 4'b0100;
      4'd0:    wall_mask_of = 4'b1000;
      default: wall_mask_of = 4'b0000;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/oad_front.sv]
// ----------------------------------------------------------------------------
// oad_front: input stage
// Registers one sample beat, decodes near/zero and forms the weighted terms.
// ----------------------------------------------------------------------------
`default_nettype none

module oad_front #(
  parameter int NUM_SENSORS = oad_pkg::NUM_SENSORS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [oad_pkg::IDX_W-1:0]  in_idx,
  input  wire logic [oad_pkg::RD_W-1:0]   in_reading,
  input  wire logic                       in_last,
  input  wire logic                       advance,
  output oad_pkg::stage_t                 stage
);

  logic                         in_range;
  logic                         near;
  logic [13:0]                  times10;
  logic [oad_pkg::MOD_W-1:0]    mod;
  logic [oad_pkg::WT_W-1:0]     lw;
  logic [oad_pkg::WT_W-1:0]     rw;
  oad_pkg::stage_t              stage_next;

  assign in_ready = !stage.valid || advance;

  // decode and weight the incoming sample
  always_comb begin
    in_range = ({1'b0, in_idx} < 5'(NUM_SENSORS));
    near     = in_range && (in_reading >= oad_pkg::NEAR_LEVEL);
    times10  = {in_reading, 3'b000} + {3'b000, in_reading, 1'b0};
    mod      = oad_pkg::MOD_W'(times10 - oad_pkg::MOD_OFFSET);
    lw       = near ? oad_pkg::left_weight(in_idx) : '0;
    rw       = near ? oad_pkg::right_weight(in_idx) : '0;
    stage_next.valid     = 1'b1;
    stage_next.last      = in_last;
    stage_next.near      = near;
    stage_next.zero      = in_range && (in_reading == '0);
    stage_next.wall_mask = oad_pkg::wall_mask_of(in_idx);
    stage_next.lprod     = {{oad_pkg::MOD_W{1'b0}}, lw} * {{oad_pkg::WT_W{1'b0}}, mod};
    stage_next.rprod     = {{oad_pkg::MOD_W{1'b0}}, rw} * {{oad_pkg::WT_W{1'b0}}, mod};
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage <= stage_next;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/oad_core.sv]
// ----------------------------------------------------------------------------
// oad_core: accumulators, wall flags, mode machine and result register
// Folds each decoded sample into the totals and emits a result on tick end.
// ----------------------------------------------------------------------------
`default_nettype none

module oad_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [oad_pkg::CFG_IX_W-1:0]  cfg_index,
  input  wire logic [oad_pkg::CFG_W-1:0]     cfg_data,
  input  wire oad_pkg::stage_t               stage,
  output logic                               advance,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [oad_pkg::OUT_TD_W-1:0]       out_data
);

  logic [oad_pkg::CFG_W-1:0]  weight_threshold;
  logic [oad_pkg::CFG_W-1:0]  full_speed;
  logic [oad_pkg::CFG_W-1:0]  turn_speed;
  logic [oad_pkg::TOT_W-1:0]  left_total;
  logic [oad_pkg::TOT_W-1:0]  right_total;
  logic [oad_pkg::WALL_W-1:0] wall_bits;
  oad_pkg::mode_t             mode;

  logic [oad_pkg::TOT_W:0]    lsum;
  logic [oad_pkg::TOT_W:0]    rsum;
  logic [oad_pkg::TOT_W-1:0]  left_total_next;
  logic [oad_pkg::TOT_W-1:0]  right_total_next;
  logic [oad_pkg::WALL_W-1:0] wall_bits_next;
  logic [25:0]                limit;
  logic                       lhigh;
  logic                       rhigh;
  oad_pkg::mode_t             mode_next;
  logic [oad_pkg::SPD_W-1:0]  fs;
  logic [oad_pkg::SPD_W-1:0]  ts;
  logic [oad_pkg::SPD_W-1:0]  ts_neg;
  logic [oad_pkg::SPD_W-1:0]  ls;
  logic [oad_pkg::SPD_W-1:0]  rs;
  logic [oad_pkg::DM_W-1:0]   dm;

  // a tick-end sample waits while the result register is still full
  assign advance = stage.valid && (!stage.last || !out_valid || out_ready);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_threshold <= oad_pkg::THRESHOLD_RST;
      full_speed       <= oad_pkg::FULL_SPEED_RST;
      turn_speed       <= oad_pkg::TURN_SPEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        oad_pkg::REG_WEIGHT_THRESHOLD: weight_threshold <= cfg_data;
        oad_pkg::REG_FULL_SPEED:       full_speed       <= cfg_data;
        oad_pkg::REG_TURN_SPEED:       turn_speed       <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturating accumulate and wall flag update
  always_comb begin
    lsum = {1'b0, left_total} + {3'b000, stage.lprod};
    rsum = {1'b0, right_total} + {3'b000, stage.rprod};
    left_total_next  = lsum[oad_pkg::TOT_W] ? '1 : lsum[oad_pkg::TOT_W-1:0];
    right_total_next = rsum[oad_pkg::TOT_W] ? '1 : rsum[oad_pkg::TOT_W-1:0];
    if (stage.zero) begin
      wall_bits_next = wall_bits & ~stage.wall_mask;
    end else if (stage.near) begin
      wall_bits_next = wall_bits | stage.wall_mask;
    end else begin
      wall_bits_next = wall_bits;
    end
  end

  // mode machine on the updated totals
  always_comb begin
    limit = {weight_threshold, 10'b0};
    lhigh = {4'b0000, left_total_next} > limit;
    rhigh = {4'b0000, right_total_next} > limit;
    case (mode)
      oad_pkg::MODE_LEFT, oad_pkg::MODE_RIGHT: begin
        mode_next = (lhigh || rhigh) ? mode : oad_pkg::MODE_FWD;
      end
      default: begin
        if (lhigh) begin
          mode_next = oad_pkg::MODE_LEFT;
        end else if (rhigh) begin
          mode_next = oad_pkg::MODE_RIGHT;
        end else begin
          mode_next = oad_pkg::MODE_FWD;
        end
      end
    endcase
  end

  // wheel speeds for the new mode
  always_comb begin
    fs     = {1'b0, full_speed};
    ts     = {1'b0, turn_speed};
    ts_neg = oad_pkg::SPD_W'(0) - ts;
    case (mode_next)
      oad_pkg::MODE_LEFT: begin
        ls = ts;
        rs = ts_neg;
        dm = oad_pkg::DRIVE_LEFT;
      end
      oad_pkg::MODE_RIGHT: begin
        ls = ts_neg;
        rs = ts;
        dm = oad_pkg::DRIVE_RIGHT;
      end
      default: begin
        ls = fs;
        rs = fs;
        dm = oad_pkg::DRIVE_FORWARD;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_total  <= '0;
      right_total <= '0;
      wall_bits   <= '0;
      mode        <= oad_pkg::MODE_FWD;
    end else if (advance) begin
      wall_bits <= wall_bits_next;
      if (stage.last) begin
        left_total  <= '0;
        right_total <= '0;
        mode        <= mode_next;
      end else begin
        left_total  <= left_total_next;
        right_total <= right_total_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && stage.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage.last) begin
      out_data <= {wall_bits_next, dm, rs, ls};
    end
  end

endmodule

`default_nettype wire

[rtl/obstacle_avoidance_drive_fsm.sv]
// A tick-end sample beat is held in the input register, then in the result register.
// Throughput: one sample beat per cycle when not stalled by a full result register.
// A tick-end beat waits in the input register only while the result register is full.
// Reset (synchronous, rst high) clears totals, wall flags, mode and both valid flags
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// obstacle_avoidance_drive_fsm: weighted range-sensor obstacle avoidance
// Sample stream in, wheel speed command out once per control tick.
// ----------------------------------------------------------------------------
`default_nettype none

module obstacle_avoidance_drive_fsm #(
  parameter int NUM_SENSORS = oad_pkg::NUM_SENSORS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [oad_pkg::CFG_IX_W-1:0]  cfg_index,
  input  wire logic [oad_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // sensor_index[3:0], sensor_reading[13:4], zero pad[15:14]
  input  wire logic [oad_pkg::IN_TD_W-1:0]   s_tdata,
  input  wire logic                          s_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // left_speed[16:0], right_speed[33:17], drive_mode[35:34], wall_flags[39:36]
  output logic [oad_pkg::OUT_TD_W-1:0]       m_tdata
);

  oad_pkg::stage_t stage;
  logic            advance;

  oad_front #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_idx     (s_tdata[3:0]),
    .in_reading (s_tdata[13:4]),
    .in_last    (s_tlast),
    .advance    (advance),
    .stage      (stage)
  );

  oad_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .advance   (advance),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

[rtl/oad_checker.sv]
// ----------------------------------------------------------------------------
// oad_checker: port-level checks of the drive controller
// Result beat holding and reset clearing, mode coding and speed pairing per mode.
// ----------------------------------------------------------------------------
`default_nettype none

module oad_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [oad_pkg::OUT_TD_W-1:0]   m_tdata
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat present after reset");

  // forward drives both wheels alike
  a_fwd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[35:34] == oad_pkg::DRIVE_FORWARD) |->
      m_tdata[16:0] == m_tdata[33:17])
    else $error("forward beat with unequal wheel speeds");

  // turning spins in place and the mode code is never unused
  a_turn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[35:34] != oad_pkg::DRIVE_FORWARD) |->
      ((m_tdata[35:34] == oad_pkg::DRIVE_LEFT) || (m_tdata[35:34] == oad_pkg::DRIVE_RIGHT)) &&
      (17'(m_tdata[16:0] + m_tdata[33:17]) == 17'd0))
    else $error("turning beat with bad mode or unbalanced speeds");

endmodule

bind obstacle_avoidance_drive_fsm oad_checker u_oad_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
